@@ rtl/c3_photosynthesis_rate_defines.svh @@
// Assertion macros for the C3 photosynthesis rate block.
// Taken in by the checker; no other dependencies.
`ifndef C3_PHOTOSYNTHESIS_RATE_DEFINES_SVH
`define C3_PHOTOSYNTHESIS_RATE_DEFINES_SVH

// same-cycle implication
`define C3PR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("c3pr check failed");

// next-cycle implication
`define C3PR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("c3pr check failed");

`endif

@@ rtl/c3pr_pkg.sv @@
// Shared types, constants and saturation helpers for the C3 photosynthesis block.
// No dependencies.
package c3pr_pkg;

    localparam int C3PR_QW = 63;
    localparam logic [C3PR_QW-1:0] C3PR_CAP = 63'h4000_0000_0000_0000;
    localparam logic signed [31:0] C3PR_TOP = 32'sh7fff_ffff;

    localparam logic [31:0] C3PR_OXY_RST   = 32'd13762560;
    localparam logic [16:0] C3PR_ALPHA_RST = 17'd0;
    localparam logic [15:0] C3PR_EC_RST    = 16'd16384;
    localparam logic [15:0] C3PR_EO_RST    = 16'd16384;

    typedef enum logic [1:0] {
        C3PR_REG_OXY,
        C3PR_REG_ALPHA,
        C3PR_REG_EC,
        C3PR_REG_EO
    } t_c3pr_reg;

    typedef enum logic [1:0] {
        C3PR_SEL_WC,
        C3PR_SEL_WJ,
        C3PR_SEL_WP
    } t_c3pr_sel;

    typedef struct packed {
        logic [31:0] ci_co2;
        logic [31:0] gamma_star;
        logic [31:0] j_rate;
        logic [31:0] kc_const;
        logic [31:0] ko_const;
        logic [31:0] resp_rate;
        logic [31:0] tpu_rate;
        logic [31:0] vcmax_rate;
    } t_c3pr_in;

    typedef struct packed {
        logic signed [31:0] net_rate;
        logic signed [31:0] rubisco_net;
        logic signed [31:0] regen_net;
        logic signed [31:0] tpu_net;
        logic signed [31:0] carbox_rate;
        logic signed [31:0] rubisco_carbox;
        logic signed [31:0] regen_carbox;
        logic signed [31:0] tpu_carbox;
        logic               tpu_unlimited;
    } t_c3pr_out;

    function automatic logic signed [31:0] c3pr_sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return C3PR_TOP;
        end else if (v < -66'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return signed'(v[31:0]);
        end
    endfunction

    function automatic logic signed [31:0] c3pr_satu(input logic [C3PR_QW-1:0] w);
        if (w > 63'd2147483647) begin
            return C3PR_TOP;
        end else begin
            return signed'(w[31:0]);
        end
    endfunction

endpackage

@@ rtl/c3pr_pdiv.sv @@
// Pipelined restoring divider, one quotient bit per stage, result capped at 2^62.
// Zero divisor gives the cap. Depends on c3pr_pkg.
module c3pr_pdiv import c3pr_pkg::*; #(
    parameter int NW = 64,
    parameter int DW = 32,
    parameter int SW = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [NW-1:0]      i_num,
    input  logic [DW-1:0]      i_den,
    input  logic [SW-1:0]      i_side,
    output logic               o_valid,
    output logic [C3PR_QW-1:0] o_quot,
    output logic [SW-1:0]      o_side
);
    localparam int XW = (NW > DW + C3PR_QW) ? NW : DW + C3PR_QW;

    logic               r_v    [0:C3PR_QW];
    logic               r_ovf  [0:C3PR_QW];
    logic [C3PR_QW-1:0] r_q    [0:C3PR_QW];
    logic [SW-1:0]      r_side [0:C3PR_QW];
    logic [XW-1:0]      r_rem  [0:C3PR_QW-1];
    logic [DW-1:0]      r_den  [0:C3PR_QW-1];

    logic [XW-1:0] w_num_x;
    logic [XW-1:0] w_lim;
    logic [C3PR_QW-1:0] w_qf;

    assign w_num_x = XW'(i_num);
    assign w_lim   = XW'(i_den) << C3PR_QW;

    // entry stage: quotient of 2^63 or more saturates anyway
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= w_num_x;
            r_den[0]  <= i_den;
            r_q[0]    <= '0;
            r_ovf[0]  <= (i_den == '0) || (w_num_x >= w_lim);
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 1; k <= C3PR_QW; k++) begin : g_step
        localparam int B = C3PR_QW - k;
        logic [XW-1:0] w_sh;
        logic          w_ge;

        assign w_sh = XW'(r_den[k-1]) << B;
        assign w_ge = r_rem[k-1] >= w_sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k]    <= {r_q[k-1][C3PR_QW-2:0], w_ge};
                r_ovf[k]  <= r_ovf[k-1];
                r_side[k] <= r_side[k-1];
            end
        end

        if (k < C3PR_QW) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_ge ? (r_rem[k-1] - w_sh) : r_rem[k-1];
                    r_den[k] <= r_den[k-1];
                end
            end
        end
    end

    assign w_qf    = r_q[C3PR_QW];
    assign o_valid = r_v[C3PR_QW];
    assign o_side  = r_side[C3PR_QW];
    assign o_quot  = (r_ovf[C3PR_QW] || (w_qf > C3PR_CAP)) ? C3PR_CAP : w_qf;

endmodule

@@ rtl/c3pr_skid.sv @@
// Output register plus one skid entry; the pipeline advances while the skid is empty.
// Depends on c3pr_pkg.
module c3pr_skid import c3pr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_c3pr_out i_data,
    output logic      o_en,
    output logic      o_valid,
    input  logic      i_ready,
    output t_c3pr_out o_data
);
    logic      r_out_v;
    logic      r_skid_v;
    t_c3pr_out r_out;
    t_c3pr_out r_skid;
    logic      w_take;
    logic      w_push;

    assign o_en    = !r_skid_v;
    assign w_take  = r_out_v && i_ready;
    assign w_push  = o_en && i_valid;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_take) begin
                r_skid_v <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_v || w_take) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (w_take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (w_push) begin
            if (!r_out_v || w_take) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

endmodule

@@ rtl/c3_photosynthesis_rate.sv @@
// C3 leaf photosynthesis rate, fixed point, fully pipelined.
// Depends on c3pr_pkg, c3pr_pdiv and c3pr_skid.
//
// Usage:
//   Input channel i_in_valid/o_in_ready carries one leaf state per item;
//   output channel o_out_valid/i_out_ready carries the limiting rates,
//   the four net rates and the TPU flag. The config port (i_cfg_we,
//   i_cfg_idx, i_cfg_wdata) writes O2, glycolate fraction and the two
//   electron ratios; write it only while no item is in flight.
//   Throughput: one item per clock while the output is not stalled. The
//   pipeline holds three chained divider layers (Kc * (Ko + O) / Ko term,
//   the three carboxylation limits, the three net-rate corrections).
//   Reset clears all valid bits and loads the default register values.
//   When the receiver stalls, one result waits in the output register and
//   the pipeline keeps moving until the skid entry fills; o_in_ready then
//   drops and the whole pipeline holds until the output drains.
module c3_photosynthesis_rate import c3pr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_c3pr_in    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_c3pr_out   o_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata
);
    logic [31:0] r_oxy;
    logic [16:0] r_alpha;
    logic [15:0] r_ec;
    logic [15:0] r_eo;
    logic        w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oxy   <= C3PR_OXY_RST;
            r_alpha <= C3PR_ALPHA_RST;
            r_ec    <= C3PR_EC_RST;
            r_eo    <= C3PR_EO_RST;
        end else if (i_cfg_we) begin
            case (t_c3pr_reg'(i_cfg_idx))
                C3PR_REG_OXY:   r_oxy   <= i_cfg_wdata;
                C3PR_REG_ALPHA: r_alpha <= i_cfg_wdata[16:0];
                C3PR_REG_EC:    r_ec    <= i_cfg_wdata[15:0];
                C3PR_REG_EO:    r_eo    <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign o_in_ready = w_en;

    // ---- stage 1: Kc * (Ko + O)
    logic        r1_v;
    t_c3pr_in    r1_d;
    logic [64:0] r1_kn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_d  <= i_in_data;
            r1_kn <= 65'(i_in_data.kc_const)
                   * (65'(i_in_data.ko_const) + 65'(r_oxy));
        end
    end

    logic               w_k_v;
    logic [C3PR_QW-1:0] w_k;
    t_c3pr_in           w_k_d;

    c3pr_pdiv #(.NW(65), .DW(32), .SW($bits(t_c3pr_in))) u_kdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r1_v),
        .i_num   (r1_kn),
        .i_den   (r1_d.ko_const),
        .i_side  (r1_d),
        .o_valid (w_k_v),
        .o_quot  (w_k),
        .o_side  (w_k_d)
    );

    // ---- stage 2: numerators and divisors of the three limits
    logic        w2_cz;
    logic [31:0] w2_c;
    logic [31:0] w2_g;
    logic [31:0] w2_j;
    logic [33:0] w2_tp3;
    logic [18:0] w2_m;
    logic [50:0] w2_gm;
    logic [50:0] w2_cs;

    assign w2_c   = w_k_d.ci_co2;
    assign w2_g   = w_k_d.gamma_star;
    assign w2_j   = w_k_d.j_rate;
    assign w2_cz  = (w2_c == '0);
    assign w2_tp3 = 34'(w_k_d.tpu_rate) + {1'b0, w_k_d.tpu_rate, 1'b0};
    assign w2_m   = 19'h1_0000 + 19'(r_alpha) * 19'd3;
    assign w2_gm  = 51'(w2_g) * 51'(w2_m);
    assign w2_cs  = 51'({w2_c, 16'h0000});

    logic        r2_v;
    logic [63:0] r2_na;
    logic [62:0] r2_da;
    logic [75:0] r2_nb;
    logic [49:0] r2_db;
    logic [81:0] r2_nc;
    logic [47:0] r2_dc;
    logic        r2_unlim;
    logic        r2_cz;
    logic [31:0] r2_c;
    logic [31:0] r2_g;
    logic [31:0] r2_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= w_k_v;
        end
    end

    // at zero CO2 the Rubisco slot divides G * Vcmax by K and the
    // regeneration slot divides J * 2^11 by eo
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_na    <= 64'(w_k_d.vcmax_rate) * 64'(w2_cz ? w2_g : w2_c);
            r2_da    <= 63'(w2_c) + w_k;
            r2_nb    <= w2_cz ? (76'(w2_j) << 11)
                              : (76'(64'(w2_j) * 64'(w2_c)) << 12);
            r2_db    <= w2_cz ? 50'(r_eo)
                              : (50'(r_ec) * 50'(w2_c) + ((50'(r_eo) * 50'(w2_g)) << 1));
            r2_nc    <= 82'(66'(w2_tp3) * 66'(w2_c)) << 16;
            r2_dc    <= 48'(w2_cs - w2_gm);
            r2_unlim <= !(w2_cs > w2_gm);
            r2_cz    <= w2_cz;
            r2_c     <= w2_c;
            r2_g     <= w2_g;
            r2_rd    <= w_k_d.resp_rate;
        end
    end

    logic               w_a_v;
    logic [C3PR_QW-1:0] w_wc;
    logic [C3PR_QW-1:0] w_wj;
    logic [C3PR_QW-1:0] w_wp;
    logic [95:0]        w_a_side;
    logic               w_b_cz;
    logic               w_c_unlim;

    c3pr_pdiv #(.NW(64), .DW(63), .SW(96)) u_wcdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r2_v),
        .i_num   (r2_na),
        .i_den   (r2_da),
        .i_side  ({r2_c, r2_g, r2_rd}),
        .o_valid (w_a_v),
        .o_quot  (w_wc),
        .o_side  (w_a_side)
    );

    c3pr_pdiv #(.NW(76), .DW(50), .SW(1)) u_wjdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r2_v),
        .i_num   (r2_nb),
        .i_den   (r2_db),
        .i_side  (r2_cz),
        .o_valid (),
        .o_quot  (w_wj),
        .o_side  (w_b_cz)
    );

    c3pr_pdiv #(.NW(82), .DW(48), .SW(1)) u_wpdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r2_v),
        .i_num   (r2_nc),
        .i_den   (r2_dc),
        .i_side  (r2_unlim),
        .o_valid (),
        .o_quot  (w_wp),
        .o_side  (w_c_unlim)
    );

    // ---- stage 3: pick the limit, partial products of G * W
    logic [C3PR_QW-1:0] w3_w [3];
    logic [31:0]        w3_g;
    t_c3pr_sel          w3_sel;

    assign w3_w[0] = w_wc;
    assign w3_w[1] = w_wj;
    assign w3_w[2] = w_wp;
    assign w3_g    = w_a_side[63:32];

    always_comb begin
        logic [C3PR_QW-1:0] vmin;
        if (w_wj < w_wc) begin
            w3_sel = C3PR_SEL_WJ;
            vmin   = w_wj;
        end else begin
            w3_sel = C3PR_SEL_WC;
            vmin   = w_wc;
        end
        if (!w_c_unlim && (w_wp < vmin)) begin
            w3_sel = C3PR_SEL_WP;
        end
    end

    logic               r3_v;
    logic [63:0]        r3_plo [3];
    logic [62:0]        r3_phi [3];
    logic [C3PR_QW-1:0] r3_w   [3];
    logic [31:0]        r3_c;
    logic [31:0]        r3_rd;
    t_c3pr_sel          r3_sel;
    logic               r3_unlim;
    logic               r3_cz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= w_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r3_plo[k] <= 64'(w3_g) * 64'(w3_w[k][31:0]);
                r3_phi[k] <= 63'(w3_g) * 63'(w3_w[k][62:32]);
                r3_w[k]   <= w3_w[k];
            end
            r3_c     <= w_a_side[95:64];
            r3_rd    <= w_a_side[31:0];
            r3_sel   <= w3_sel;
            r3_unlim <= w_c_unlim;
            r3_cz    <= w_b_cz;
        end
    end

    // ---- stage 4: sum partial products
    logic               r4_v;
    logic [94:0]        r4_num [3];
    logic [C3PR_QW-1:0] r4_w   [3];
    logic [31:0]        r4_c;
    logic [31:0]        r4_rd;
    t_c3pr_sel          r4_sel;
    logic               r4_unlim;
    logic               r4_cz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r4_num[k] <= 95'(r3_plo[k]) + (95'(r3_phi[k]) << 32);
                r4_w[k]   <= r3_w[k];
            end
            r4_c     <= r3_c;
            r4_rd    <= r3_rd;
            r4_sel   <= r3_sel;
            r4_unlim <= r3_unlim;
            r4_cz    <= r3_cz;
        end
    end

    // ---- net-rate corrections floor(G * W / C)
    logic               w_n_v;
    logic [C3PR_QW-1:0] w_n_q [3];
    logic [98:0]        w_n0_side;
    logic [C3PR_QW-1:0] w_n1_w;
    logic [C3PR_QW-1:0] w_n2_w;

    c3pr_pdiv #(.NW(95), .DW(32), .SW(99)) u_n0div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r4_v),
        .i_num   (r4_num[0]),
        .i_den   (r4_c),
        .i_side  ({r4_w[0], r4_rd, r4_sel, r4_unlim, r4_cz}),
        .o_valid (w_n_v),
        .o_quot  (w_n_q[0]),
        .o_side  (w_n0_side)
    );

    c3pr_pdiv #(.NW(95), .DW(32), .SW(C3PR_QW)) u_n1div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r4_v),
        .i_num   (r4_num[1]),
        .i_den   (r4_c),
        .i_side  (r4_w[1]),
        .o_valid (),
        .o_quot  (w_n_q[1]),
        .o_side  (w_n1_w)
    );

    c3pr_pdiv #(.NW(95), .DW(32), .SW(C3PR_QW)) u_n2div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r4_v),
        .i_num   (r4_num[2]),
        .i_den   (r4_c),
        .i_side  (r4_w[2]),
        .o_valid (),
        .o_quot  (w_n_q[2]),
        .o_side  (w_n2_w)
    );

    // ---- stage 5: net rates and saturation
    logic [C3PR_QW-1:0] w5_w [3];
    logic [31:0]        w5_rd;
    t_c3pr_sel          w5_sel;
    logic               w5_unlim;
    logic               w5_cz;
    t_c3pr_out          n_out;

    assign w5_w[0]  = w_n0_side[98:36];
    assign w5_w[1]  = w_n1_w;
    assign w5_w[2]  = w_n2_w;
    assign w5_rd    = w_n0_side[35:4];
    assign w5_sel   = t_c3pr_sel'(w_n0_side[3:2]);
    assign w5_unlim = w_n0_side[1];
    assign w5_cz    = w_n0_side[0];

    always_comb begin
        logic signed [65:0] net [3];
        logic signed [65:0] an;
        logic [C3PR_QW-1:0] x;
        logic [C3PR_QW-1:0] y;
        logic [C3PR_QW-1:0] vc;
        // zero CO2: the slot quotient is the whole loss term
        for (int k = 0; k < 3; k++) begin
            x = w5_cz ? '0 : w5_w[k];
            y = w5_cz ? w5_w[k] : w_n_q[k];
            net[k] = $signed({3'b000, x}) - $signed({3'b000, y})
                   - $signed({34'h0, w5_rd});
        end
        case (w5_sel)
            C3PR_SEL_WJ: begin
                an = net[1];
                vc = w5_w[1];
            end
            C3PR_SEL_WP: begin
                an = net[2];
                vc = w5_w[2];
            end
            default: begin
                an = net[0];
                vc = w5_w[0];
            end
        endcase
        if (w5_cz) begin
            an = (net[0] > net[1]) ? net[0] : net[1];
        end
        n_out.net_rate       = c3pr_sat32(an);
        n_out.rubisco_net    = c3pr_sat32(net[0]);
        n_out.regen_net      = c3pr_sat32(net[1]);
        n_out.tpu_net        = w5_unlim ? C3PR_TOP : c3pr_sat32(net[2]);
        n_out.carbox_rate    = w5_cz ? '0 : c3pr_satu(vc);
        n_out.rubisco_carbox = w5_cz ? '0 : c3pr_satu(w5_w[0]);
        n_out.regen_carbox   = w5_cz ? '0 : c3pr_satu(w5_w[1]);
        n_out.tpu_carbox     = w5_unlim ? C3PR_TOP : c3pr_satu(w5_w[2]);
        n_out.tpu_unlimited  = w5_unlim;
    end

    logic      r5_v;
    t_c3pr_out r5_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (w_en) begin
            r5_v <= w_n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_out <= n_out;
        end
    end

    c3pr_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r5_v),
        .i_data  (r5_out),
        .o_en    (w_en),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

@@ rtl/c3pr_chk.sv @@
// Port-level checks for c3_photosynthesis_rate, bound to the top level.
// Depends on c3pr_pkg and c3_photosynthesis_rate_defines.svh.
`include "c3_photosynthesis_rate_defines.svh"

module c3pr_chk import c3pr_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input t_c3pr_in    i_in_data,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_c3pr_out   o_out_data,
    input logic        i_cfg_we,
    input logic [1:0]  i_cfg_idx,
    input logic [31:0] i_cfg_wdata
);
    // stalled result holds
    `C3PR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))
    // unlimited TPU shows the top code on both TPU fields
    `C3PR_ASSERT_NOW(a_tpu_top, i_clk, i_rst_n, o_out_valid && o_out_data.tpu_unlimited, (o_out_data.tpu_net == C3PR_TOP) && (o_out_data.tpu_carbox == C3PR_TOP))
    // limiting rate never exceeds the Rubisco and regeneration limits
    `C3PR_ASSERT_NOW(a_min_rate, i_clk, i_rst_n, o_out_valid, (o_out_data.carbox_rate <= o_out_data.rubisco_carbox) && (o_out_data.carbox_rate <= o_out_data.regen_carbox))
    // input side only backs up after the output stalled
    `C3PR_ASSERT_NOW(a_ready_drop, i_clk, i_rst_n, $fell(o_in_ready), $past(o_out_valid && !i_out_ready))

endmodule

bind c3_photosynthesis_rate c3pr_chk u_c3pr_chk (.*);
